// ===== design/bpc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the barometer compensation block.
package bpc_pkg;

  localparam int unsigned NumRegs = 6;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } reg_index_t;

  localparam logic [31:0] B6_OFFSET   = 32'd4000;
  localparam logic [31:0] P_COEF_SQ   = 32'd3038;
  localparam logic [31:0] P_COEF_LIN  = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_COEF_ADD  = 32'd3791;
  localparam logic [31:0] B7_SCALE    = 32'd50000;
  localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
  localparam logic [31:0] X3_OFFSET   = 32'd32768;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_X1,
    ST_T_CHK,
    ST_T_DIV,
    ST_T_DONE,
    ST_P_SQ,
    ST_P_X1,
    ST_P_X2,
    ST_P_B3,
    ST_P_X1B,
    ST_P_X2B,
    ST_P_B4,
    ST_P_B7,
    ST_P_DIV,
    ST_P_Q,
    ST_P_SQP,
    ST_P_C1,
    ST_P_C2,
    ST_P_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic negate;
  } div_ctrl_t;

  function automatic logic [31:0] sx16(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    return 32'($signed(x) >>> n);
  endfunction

endpackage

// ===== design/bpc_divider.sv =====
// Restoring unsigned 32-bit divider, one quotient bit per cycle, optional result negate.
module bpc_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  bpc_pkg::div_ctrl_t    ctrl,
  input  logic [31:0]           dividend,
  input  logic [31:0]           divisor,
  output logic                  done,
  output logic [31:0]           quotient
);
  import bpc_pkg::*;

  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic        busy;
  logic        neg;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        count <= 6'd32;
        quo   <= dividend;
        rem   <= '0;
        dvs   <= divisor;
        neg   <= ctrl.negate;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? (32'd0 - quo) : quo;

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done lasted more than one cycle");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !ctrl.start)
    else $error("divider started while busy");
  a_count_range: assert property (@(posedge clk) disable iff (rst) busy |-> count != 6'd0)
    else $error("divider busy with zero count");
`endif

endmodule

// ===== design/barometer_temp_pressure_compensation_top.sv =====
// Top level of the barometer temperature and pressure compensation block.
// One raw conversion per transfer: command 0 compensates a temperature, command 1
// a pressure using the last temperature's B5 term. The block is busy for one item
// at a time. Two things set how long an item takes: a shared 32x32 multiplier is
// used once per cycle, and a bit-serial divider works through each division bit
// by bit. A divisor of zero skips the division, so that item finishes sooner.
// The result waits in an output register; a new item is accepted once the result
// has entered that register.
module barometer_temp_pressure_compensation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // raw_sample[18:0], zero fill
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // value[31:0], divide_error, zero fill
  output logic        m_tuser,   // kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import bpc_pkg::*;

  logic [31:0] regs [NumRegs];
  logic [31:0] temp_term;
  state_t      state, state_next;

  logic        cmd;
  logic [18:0] raw;
  logic [31:0] b6, sq, t1, t2, b3, p, res;
  logic        err;

  logic [31:0] ma, mb, prod;
  div_ctrl_t   dctrl;
  logic [31:0] ddvd, ddvs, dq;
  logic        ddone;

  logic [1:0]  oss;
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] s_num, s_den;

  assign oss = regs[REG_OSS][1:0];
  assign ac1 = sx16(regs[REG_AC1_AC2][31:16]);
  assign ac2 = sx16(regs[REG_AC1_AC2][15:0]);
  assign ac3 = sx16(regs[REG_AC3_AC4][31:16]);
  assign ac4 = {16'd0, regs[REG_AC3_AC4][15:0]};
  assign ac5 = {16'd0, regs[REG_AC5_AC6][31:16]};
  assign ac6 = {16'd0, regs[REG_AC5_AC6][15:0]};
  assign b1  = sx16(regs[REG_B1_B2][31:16]);
  assign b2  = sx16(regs[REG_B1_B2][15:0]);
  assign mc  = sx16(regs[REG_MC_MD][31:16]);
  assign md  = sx16(regs[REG_MC_MD][15:0]);

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_OSS) begin
        regs[REG_OSS] <= {30'd0, cfg_data[1:0]};
      end else if (cfg_index < REG_OSS) begin
        regs[cfg_index] <= cfg_data;
      end
    end
  end

  // Shared multiplier: operands chosen by state, product registered.
  // Where an operand is the previous product, it is taken from prod directly.
  always_comb begin
    ma = t1;
    mb = t1;
    case (state)
      ST_T_X1:  begin ma = {16'd0, raw[15:0]} - ac6; mb = ac5; end
      ST_P_SQ:  begin ma = b6; mb = b6; end
      ST_P_X1:  begin ma = asr(prod, 5'd12); mb = b2; end
      ST_P_X2:  begin ma = ac2; mb = b6; end
      ST_P_X1B: begin ma = ac3; mb = b6; end
      ST_P_X2B: begin ma = b1; mb = sq; end
      ST_P_B4:  begin
        ma = ac4;
        mb = asr(t1 + asr(prod, 5'd16) + 32'd2, 5'd2) + X3_OFFSET;
      end
      ST_P_B7:  begin ma = {13'd0, raw} - b3; mb = B7_SCALE >> oss; end
      ST_P_SQP: begin ma = asr(p, 5'd8); mb = asr(p, 5'd8); end
      ST_P_C1:  begin ma = prod; mb = P_COEF_SQ; end
      ST_P_C2:  begin ma = p; mb = P_COEF_LIN; end
      default:  begin ma = t1; mb = t1; end
    endcase
  end

  always_ff @(posedge clk) prod <= 32'(64'(ma) * 64'(mb));

  // Signed temperature quotient mapped onto the unsigned divider.
  // In the temperature check state t1 is still stale, so use prod directly there.
  assign s_num = (mc << 11);
  assign s_den = asr(prod, 5'd15) + md;

  always_comb begin
    dctrl = '0;
    ddvd  = '0;
    ddvs  = '0;
    if (state == ST_T_CHK && s_den != 32'd0) begin
      dctrl.start  = 1'b1;
      dctrl.negate = s_num[31] ^ s_den[31];
      ddvd = s_num[31] ? 32'd0 - s_num : s_num;
      ddvs = s_den[31] ? 32'd0 - s_den : s_den;
    end else if (state == ST_P_DIV && t2 != 32'd0) begin
      dctrl.start = 1'b1;
      ddvd = prod[31] ? prod : {prod[30:0], 1'b0};
      ddvs = t2;
    end
  end

  bpc_divider u_div (
    .clk(clk), .rst(rst), .ctrl(dctrl), .dividend(ddvd), .divisor(ddvs),
    .done(ddone), .quotient(dq)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = s_tuser ? ST_P_SQ : ST_T_X1;
      ST_T_X1:   state_next = ST_T_CHK;
      ST_T_CHK:  state_next = (s_den == 32'd0) ? ST_OUT : ST_T_DIV;
      ST_T_DIV:  if (ddone) state_next = ST_T_DONE;
      ST_T_DONE: state_next = ST_OUT;
      ST_P_SQ:   state_next = ST_P_X1;
      ST_P_X1:   state_next = ST_P_X2;
      ST_P_X2:   state_next = ST_P_B3;
      ST_P_B3:   state_next = ST_P_X1B;
      ST_P_X1B:  state_next = ST_P_X2B;
      ST_P_X2B:  state_next = ST_P_B4;
      ST_P_B4:   state_next = ST_P_B7;
      ST_P_B7:   state_next = ST_P_DIV;
      ST_P_DIV:  state_next = (t2 == 32'd0) ? ST_OUT : ST_P_Q;
      ST_P_Q:    if (ddone) state_next = ST_P_SQP;
      ST_P_SQP:  state_next = ST_P_C1;
      ST_P_C1:   state_next = ST_P_C2;
      ST_P_C2:   state_next = ST_P_DONE;
      ST_P_DONE: state_next = ST_OUT;
      ST_OUT:    if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Datapath registers. Each multiply result is registered in prod and read in the next state.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_term <= '0;
    end else begin
      case (state)
        ST_IDLE: if (s_tvalid) begin
          cmd <= s_tuser;
          raw <= s_tdata[18:0];
          err <= 1'b0;
          res <= '0;
          b6  <= temp_term - B6_OFFSET;
        end
        ST_T_CHK: begin
          t1 <= asr(prod, 5'd15);
          if (asr(prod, 5'd15) + md == 32'd0) err <= 1'b1;
        end
        ST_T_DONE: begin
          temp_term <= t1 + dq;
          res <= asr(t1 + dq + 32'd8, 5'd4);
        end
        ST_P_X1:  sq <= asr(prod, 5'd12);
        ST_P_X2:  t1 <= asr(prod, 5'd11);
        ST_P_B3:  b3 <= asr((((ac1 << 2) + t1 + asr(prod, 5'd11)) << oss) + 32'd2, 5'd2);
        ST_P_X2B: t1 <= asr(prod, 5'd13);
        ST_P_B4:  t1 <= asr(t1 + asr(prod, 5'd16) + 32'd2, 5'd2);
        ST_P_B7:  t2 <= prod >> 15;
        ST_P_DIV: begin
          t1 <= prod;
          if (t2 == 32'd0) err <= 1'b1;
        end
        ST_P_Q:   if (ddone) p <= t1[31] ? {dq[30:0], 1'b0} : dq;
        ST_P_C1:  t1 <= prod;
        ST_P_C2:  t2 <= asr(prod, 5'd16);
        ST_P_DONE: res <= p + asr(t2 + asr(prod, 5'd16) + P_COEF_ADD, 5'd4);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tuser  <= cmd;
        m_tdata  <= {7'd0, err, err ? 32'd0 : res};
      end
    end
  end

`ifndef ASSERT_OFF
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready)
    else $error("ready while busy");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[32]) |-> (m_tdata[31:0] == 32'd0))
    else $error("error result with nonzero value");
  a_out_from_state: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_OUT))
    else $error("result appeared outside output state");
`endif

endmodule
